FILE: hdl/kls_pkg.sv
// ----------------------------------------------------------------------------
// kls_pkg
// Shared constants and types of the streaming K-th largest select unit.
// ----------------------------------------------------------------------------
`default_nettype none

package kls_pkg;

  // Largest rank held; sets the number of cells in the chain.
  localparam int MAX_RANK = 64;
  // Width of a rank value (must hold MAX_RANK itself).
  localparam int RANK_W   = $clog2(MAX_RANK + 1);
  // Width of a cell index.
  localparam int IDX_W    = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  // Width of a Q16.16 sample.
  localparam int VAL_W    = 32;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic                    ins;     // insert the sample this cycle
    logic                    clr;     // drop all held values
    logic signed [VAL_W-1:0] sample;  // value being inserted
  } kls_ctl_t;

  // What a cell hands to its right-hand neighbor.
  typedef struct packed {
    logic                    valid;   // cell holds a value inside the rank
    logic                    lt;      // held value is below the sample
    logic signed [VAL_W-1:0] value;   // held value
  } kls_link_t;

endpackage

`default_nettype wire

FILE: hdl/kls_if.sv
// ----------------------------------------------------------------------------
// kls_if
// Valid/ready channel interfaces for samples, results and rank writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface kls_in_if;
  logic                           valid;
  logic                           ready;
  logic signed [kls_pkg::VAL_W-1:0] sample_value;
  logic                           last_item;

  modport source (output valid, output sample_value, output last_item, input ready);
  modport sink   (input valid, input sample_value, input last_item, output ready);
endinterface

interface kls_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [kls_pkg::VAL_W-1:0] kth_value;
  logic                           enough_items;

  modport source (output valid, output kth_value, output enough_items, input ready);
  modport sink   (input valid, input kth_value, input enough_items, output ready);
endinterface

interface kls_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] rank_k;

  modport source (output valid, output rank_k, input ready);
  modport sink   (input valid, input rank_k, output ready);
endinterface

`default_nettype wire

FILE: hdl/kls_cell.sv
// ----------------------------------------------------------------------------
// kls_cell
// One insertion cell: holds one value of the descending list.
// ----------------------------------------------------------------------------
`default_nettype none

module kls_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire kls_pkg::kls_ctl_t ctl,
  input  wire logic              lane_on,   // cell index below the rank
  input  wire kls_pkg::kls_link_t prev,     // left-hand neighbor
  output kls_pkg::kls_link_t     link       // to right-hand neighbor
);
  import kls_pkg::*;

  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic                    valid_r, valid_nxt;
  logic                    valid_eff;
  logic                    lt_self;
  logic                    take_prev;
  logic                    take_new;

  // Compare the held value against the broadcast sample
  assign valid_eff = valid_r & lane_on;
  assign lt_self   = valid_eff & (val_r < ctl.sample);
  assign take_prev = prev.lt;
  assign take_new  = !prev.lt && prev.valid && (!valid_eff || lt_self);

  // Clear, shift right, take the sample, or hold
  always_comb begin
    val_nxt   = val_r;
    valid_nxt = valid_r;
    if (ctl.clr) begin
      valid_nxt = 1'b0;
    end else if (ctl.ins) begin
      if (take_prev) begin
        val_nxt = prev.value;
      end else if (take_new) begin
        val_nxt = ctl.sample;
      end
      valid_nxt = lane_on & (valid_eff | take_prev | take_new);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign link.valid = valid_eff;
  assign link.lt    = lt_self;
  assign link.value = val_r;

endmodule

`default_nettype wire

FILE: hdl/kls_chain.sv
// ----------------------------------------------------------------------------
// kls_chain
// Row of insertion cells and the read port for the cell at rank K.
// ----------------------------------------------------------------------------
`default_nettype none

module kls_chain (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire kls_pkg::kls_ctl_t           ctl,
  input  wire logic [kls_pkg::RANK_W-1:0]  rank_eff,   // 1..MAX_RANK
  output logic signed [kls_pkg::VAL_W-1:0] kth_val,
  output logic                             kth_valid
);
  import kls_pkg::*;

  kls_link_t            links [MAX_RANK];
  kls_link_t            head;
  logic [RANK_W-1:0]    kth_pos;
  logic [IDX_W-1:0]     kth_idx;

  // Left end of the row: always valid, never below the sample
  assign head.valid = 1'b1;
  assign head.lt    = 1'b0;
  assign head.value = '0;

  // Build the row
  for (genvar i = 0; i < MAX_RANK; i++) begin : g_cell
    logic lane_on;
    assign lane_on = (RANK_W'(i) < rank_eff);
    kls_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .lane_on (lane_on),
      .prev    ((i == 0) ? head : links[(i == 0) ? 0 : i - 1]),
      .link    (links[i])
    );
  end

  // Select the cell at rank K
  assign kth_pos   = rank_eff - RANK_W'(1);
  assign kth_idx   = kth_pos[IDX_W-1:0];
  assign kth_val   = links[kth_idx].value;
  assign kth_valid = links[kth_idx].valid;

endmodule

`default_nettype wire

FILE: hdl/kth_largest_stream_select_unit.sv
// ----------------------------------------------------------------------------
// kth_largest_stream_select_unit
// Keeps the K largest samples of a run and reports the K-th on the last one.
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle; after a run's last sample, input pauses
//   while the chain is read and cleared, which waits for a free result slot.
// Result: the last sample sets a pending flag; the slot is loaded from the
//   chain once that flag is set and the slot is free or being read.
// Reset: clears the cells' valid bits, the run counters and the result slot;
//   rank_k returns to 1. No clearing pass is needed.
`default_nettype none

module kth_largest_stream_select_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  kls_in_if.sink     in_stream,
  kls_out_if.source  out_result,
  kls_cfg_if.sink    cfg_wr
);
  import kls_pkg::*;

  logic [6:0]              rank_k_r;
  logic [RANK_W-1:0]       rank_eff;
  logic [RANK_W-1:0]       seen_r, seen_nxt;
  logic signed [VAL_W-1:0] first_r, first_nxt;
  logic                    pend_r, pend_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0] out_val_r, out_val_nxt;
  logic                    out_enough_r, out_enough_nxt;
  logic                    in_acc;
  logic                    load_out;
  logic signed [VAL_W-1:0] kth_val;
  logic                    kth_valid;
  kls_ctl_t                ctl;

  // Rank register
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_k_r <= 7'd1;
    end else if (cfg_wr.valid) begin
      rank_k_r <= cfg_wr.rank_k;
    end
  end

  // Clamp rank to 1..MAX_RANK
  always_comb begin
    if (rank_k_r == '0) begin
      rank_eff = RANK_W'(1);
    end else if (32'(rank_k_r) > MAX_RANK) begin
      rank_eff = RANK_W'(MAX_RANK);
    end else begin
      rank_eff = RANK_W'(rank_k_r);
    end
  end

  // Handshakes
  assign in_stream.ready = !pend_r;
  assign in_acc          = in_stream.valid & !pend_r;
  assign load_out        = pend_r & (!out_valid_r | out_result.ready);

  assign ctl.ins    = in_acc;
  assign ctl.clr    = load_out;
  assign ctl.sample = in_stream.sample_value;

  kls_chain u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .rank_eff  (rank_eff),
    .kth_val   (kth_val),
    .kth_valid (kth_valid)
  );

  // Run bookkeeping and result slot
  always_comb begin
    seen_nxt       = seen_r;
    first_nxt      = first_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r;
    out_val_nxt    = out_val_r;
    out_enough_nxt = out_enough_r;

    if (out_valid_r && out_result.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (in_acc) begin
      if (seen_r == '0) begin
        first_nxt = in_stream.sample_value;
      end
      if (32'(seen_r) < MAX_RANK) begin
        seen_nxt = seen_r + RANK_W'(1);
      end
      pend_nxt = in_stream.last_item;
    end

    if (load_out) begin
      out_valid_nxt  = 1'b1;
      out_val_nxt    = kth_valid ? kth_val : first_r;
      out_enough_nxt = kth_valid;
      seen_nxt       = '0;
      first_nxt      = '0;
      pend_nxt       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      first_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      seen_r      <= seen_nxt;
      first_r     <= first_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_val_r    <= out_val_nxt;
    out_enough_r <= out_enough_nxt;
  end

  assign out_result.valid        = out_valid_r;
  assign out_result.kth_value    = out_val_r;
  assign out_result.enough_items = out_enough_r;

endmodule

`default_nettype wire

FILE: hdl/kls_checker.sv
// ----------------------------------------------------------------------------
// kls_checker
// Port-level checks of the K-th largest select unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kls_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        in_last,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic signed [kls_pkg::VAL_W-1:0] out_kth,
  input wire logic                        out_enough
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kth) && $stable(out_enough))
    else $error("result changed while stalled");

  // Pause input for read-out after a last transaction
  a_last_pause: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input taken during read-out");

  // Resume input only with a result in the slot
  a_resume_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_ready) |-> out_valid)
    else $error("input resumed without a result");

endmodule

bind kth_largest_stream_select_unit kls_checker u_kls_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_stream.valid),
  .in_ready   (in_stream.ready),
  .in_last    (in_stream.last_item),
  .out_valid  (out_result.valid),
  .out_ready  (out_result.ready),
  .out_kth    (out_result.kth_value),
  .out_enough (out_result.enough_items)
);

`default_nettype wire

FILE: tb/sv/kls_checker.sv
// ----------------------------------------------------------------------------
// kls_tb_checker
// Watches the sample, result and rank channels of the K-th largest select
// unit. It keeps its own sorted list of the largest samples per run and
// compares every result transaction against the oldest predicted one.
// ----------------------------------------------------------------------------
module kls_tb_checker (
  input  logic clk,
  input  logic rst_n,
  kls_in_if    in_ch,
  kls_out_if   out_ch,
  kls_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  import kls_pkg::*;

  typedef struct packed {
    logic signed [VAL_W-1:0] kth_value;
    logic                    enough_items;
  } kth_result_t;

  // Predicted results, oldest first
  kth_result_t             expected_kth[$];

  // Largest samples of the current run, largest first
  logic signed [VAL_W-1:0] top_values [MAX_RANK];
  int unsigned             held_count;
  int unsigned             run_length;
  logic signed [VAL_W-1:0] run_first;
  logic [6:0]              rank_reg;

  // Map the raw register onto the rank actually used
  function automatic int unsigned effective_rank(input logic [6:0] k);
    if (k == 7'd0) return 1;
    if (k > MAX_RANK) return MAX_RANK;
    return k;
  endfunction

  // Fold one sample into the run; queue a result on the last one
  function automatic void absorb_sample(input logic signed [VAL_W-1:0] v,
                                        input logic last);
    int unsigned k;
    int unsigned pos;
    kth_result_t res;
    k = effective_rank(rank_reg);
    // a smaller rank written mid-run drops the tail for good
    if (held_count > k) held_count = k;
    if (run_length == 0) run_first = v;
    if (run_length < MAX_RANK) run_length++;
    pos = held_count;
    while (pos > 0 && top_values[pos-1] < v) begin
      if (pos < k) top_values[pos] = top_values[pos-1];
      pos--;
    end
    if (pos < k) top_values[pos] = v;
    if (held_count < k) held_count++;
    if (last) begin
      if (held_count >= k) begin
        res.kth_value    = top_values[k-1];
        res.enough_items = 1'b1;
      end else begin
        res.kth_value    = run_first;
        res.enough_items = 1'b0;
      end
      expected_kth = {expected_kth, res};
      held_count = 0;
      run_length = 0;
      run_first  = '0;
    end
  endfunction

  // Track transactions on every edge and compare results in order
  always @(posedge clk) begin : monitor
    kth_result_t want;
    int          errs;
    errs = 0;
    if (!rst_n) begin
      held_count = 0;
      run_length = 0;
      run_first  = '0;
      rank_reg   = 7'd1;
      expected_kth.delete();
      fail_count      <= 0;
      pending_results <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) rank_reg = cfg_ch.rank_k;
      if (in_ch.valid && in_ch.ready)
        absorb_sample(in_ch.sample_value, in_ch.last_item);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_kth.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual kth_value=%0d enough_items=%0b",
                   $time, out_ch.kth_value, out_ch.enough_items);
          errs++;
        end else begin
          want = expected_kth.pop_front();
          if (out_ch.kth_value !== want.kth_value) begin
            $display("%0t: kth_value mismatch: expected %0d, actual %0d",
                     $time, want.kth_value, out_ch.kth_value);
            errs++;
          end
          if (out_ch.enough_items !== want.enough_items) begin
            $display("%0t: enough_items mismatch: expected %0b, actual %0b",
                     $time, want.enough_items, out_ch.enough_items);
            errs++;
          end
        end
      end
      fail_count      <= fail_count + errs;
      pending_results <= expected_kth.size();
    end
  end

endmodule

FILE: tb/sv/kth_largest_stream_select_unit_tb.sv
// ----------------------------------------------------------------------------
// kth_largest_stream_select_unit_tb
// Drives runs of signed Q16.16 samples into the select unit under a range of
// rank settings, with bursty input, a stalling receiver and long output
// hold-offs, and leaves all checking to kls_tb_checker.
// ----------------------------------------------------------------------------
module kth_largest_stream_select_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kls_pkg::*;

  localparam int          STOP_ITEMS   = 1170;
  localparam int          HOLD_CYCLES  = 300;
  localparam int unsigned CYCLE_LIMIT  = 600000;

  logic clk;
  logic rst_n;

  kls_in_if  in_ch();
  kls_out_if out_ch();
  kls_cfg_if cfg_ch();

  int fail_count;
  int pending_results;

  // Sender state shared by the stimulus tasks and the receiver
  int unsigned burst_left    = 0;
  int unsigned items_sent    = 0;
  bit          no_gaps       = 1'b0;
  int unsigned stall_req_cnt = 0;

  kth_largest_stream_select_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_ch),
    .out_result (out_ch),
    .cfg_wr     (cfg_ch)
  );

  kls_tb_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .cfg_ch          (cfg_ch),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: random stall modes, plus a long hold-off on request
  initial begin : receiver
    int unsigned hold_left;
    int unsigned mode_left;
    int unsigned rx_mode;
    int unsigned rx_tick;
    int unsigned stall_served;
    hold_left    = 0;
    mode_left    = 0;
    rx_mode      = 0;
    rx_tick      = 0;
    stall_served = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_req_cnt != stall_served) begin
        stall_served++;
        hold_left = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 160);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= $urandom_range(0, 1);
          2: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= (rx_tick % 3 != 0);
        endcase
      end
    end
  end

  // Abort a hung run
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("*** FAILED ***");
    $finish;
  end

  // Offer one sample; hold valid across back-to-back transactions in a burst
  task automatic offer_sample(input logic signed [VAL_W-1:0] value, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      if (!no_gaps && $urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 8);
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    in_ch.valid        <= 1'b1;
    in_ch.sample_value <= value;
    in_ch.last_item    <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  // Drain all results, let the pipeline settle, then write the rank
  task automatic write_rank(input logic [6:0] k);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_results != 0);
    repeat (4) @(posedge clk);
    cfg_ch.valid  <= 1'b1;
    cfg_ch.rank_k <= k;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic signed [VAL_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      // narrow ranges to force ties
      2: return int'($urandom_range(0, 6)) - 3;
      3: return (int'($urandom_range(0, 8)) - 4) * 65536;
      4: return $urandom_range(0, 1) ? -32'sd1 : 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [6:0] pick_rank();
    case ($urandom_range(0, 15))
      0: return 7'd0;
      1: return 7'd64;
      2: return 7'($urandom_range(65, 127));
      3: return 7'd127;
      4, 5, 6, 7, 8, 9: return 7'($urandom_range(1, 8));
      10, 11, 12: return 7'($urandom_range(9, 32));
      default: return 7'($urandom_range(33, 63));
    endcase
  endfunction

  function automatic int unsigned pick_run_length(input int unsigned k);
    case ($urandom_range(0, 7))
      0: return $urandom_range(1, k);
      1: return k;
      2: return (k > 1) ? k - 1 : 1;
      default: return $urandom_range(k, k + 4 + k / 2);
    endcase
  endfunction

  // Stimulus and verdict
  initial begin : stimulus
    logic [6:0]  rank;
    int unsigned keff;
    int unsigned runs;
    int unsigned len;
    int unsigned phase;
    bit          run_open;
    in_ch.valid        <= 1'b0;
    in_ch.sample_value <= '0;
    in_ch.last_item    <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.rank_k      <= 7'd1;
    rst_n              <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset rank of one: single-sample runs at both extremes
    offer_sample(32'sh7FFF_FFFF, 1'b1);
    offer_sample(32'sh8000_0000, 1'b1);

    // Rank three with ties at the top
    write_rank(7'd3);
    offer_sample(-32'sd1, 1'b0);
    offer_sample(32'sh7FFF_FFFF, 1'b0);
    offer_sample(32'sh8000_0000, 1'b0);
    offer_sample(32'sd0, 1'b0);
    offer_sample(32'sh7FFF_FFFF, 1'b1);

    // Short run returns its first sample
    offer_sample(32'sh1234_5678, 1'b0);
    offer_sample(32'shEDCB_A987, 1'b1);

    // Rank zero acts as one
    write_rank(7'd0);
    offer_sample(32'sd5, 1'b0);
    offer_sample(-32'sd3, 1'b1);

    // Rank above the bound, short run
    write_rank(7'd127);
    offer_sample(32'sh0001_0000, 1'b0);
    offer_sample(32'sh0002_0000, 1'b0);
    offer_sample(32'sh0003_0000, 1'b1);

    // Lower the rank in the middle of a run
    write_rank(7'd4);
    offer_sample(32'sd10, 1'b0);
    offer_sample(32'sd20, 1'b0);
    offer_sample(32'sd30, 1'b0);
    offer_sample(32'sd40, 1'b0);
    write_rank(7'd2);
    offer_sample(32'sd5, 1'b1);

    // Random phases, each under a fresh rank
    phase    = 0;
    run_open = 1'b0;
    while (items_sent < STOP_ITEMS) begin
      rank = pick_rank();
      write_rank(rank);
      keff = (rank == 7'd0) ? 1 : ((rank > MAX_RANK) ? MAX_RANK : rank);

      // Hold the receiver off while short runs keep coming
      if (phase == 2 || phase == 15) begin
        no_gaps = 1'b1;
        stall_req_cnt <= stall_req_cnt + 1;
        repeat (40) begin
          len = $urandom_range(1, 3);
          for (int unsigned i = 0; i < len; i++) offer_sample(pick_sample(), i == len - 1);
        end
        no_gaps = 1'b0;
      end

      runs = (keff > 32) ? $urandom_range(1, 2) : $urandom_range(2, 6);
      repeat (runs) begin
        len = pick_run_length(keff);
        for (int unsigned i = 0; i < len; i++) offer_sample(pick_sample(), i == len - 1);
      end

      // Sometimes leave a run open across the next rank write
      run_open = ($urandom_range(0, 5) == 0);
      if (run_open) begin
        len = $urandom_range(1, keff + 2);
        repeat (len) offer_sample(pick_sample(), 1'b0);
      end
      phase++;
    end
    if (run_open) offer_sample(pick_sample(), 1'b1);

    // Drain and give the verdict
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
